// ----- hw/rtl/mqpaf_pkg.sv -----
// Shared types and constants for the MQTT publish and acknowledgement framer.
package mqpaf_pkg;

   // Item modes on the request channel.
   localparam logic [1:0] MODE_PUBLISH = 2'd0;
   localparam logic [1:0] MODE_DATA    = 2'd1;
   localparam logic [1:0] MODE_ACK     = 2'd2;
   localparam logic [1:0] MODE_ZERO    = 2'd3;

   // Result status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_REM_LONG = 2'd1;
   localparam logic [1:0] STATUS_BUF_LONG = 2'd2;

   // Control packet types with special handling.
   localparam logic [3:0] PUBLISH_TYPE = 4'd3;
   localparam logic [3:0] PUBREL_TYPE  = 4'd6;

   // Protocol limits and register widths.
   localparam int          MAX_LEN_W      = 29;
   localparam logic [28:0] REM_LEN_MAX    = 29'd268435455;
   localparam logic [28:0] MAX_LEN_RESET  = 29'd4096;
   localparam logic [28:0] ACK_LEN        = 29'd4;
   localparam logic [28:0] ZERO_LEN       = 29'd2;
   localparam logic [7:0]  ACK_REM_LEN    = 8'd2;
   localparam int          CMD_BYTES      = 9;

   // One input beat.
   typedef struct packed {
      logic [1:0]  mode;
      logic [3:0]  packet_type;
      logic        dup_flag;
      logic [1:0]  qos;
      logic        retain_flag;
      logic [15:0] packet_id;
      logic [15:0] topic_len;
      logic [27:0] body_len;
      logic [7:0]  data_byte;
   } req_type;

   // One output beat.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
      logic [1:0] status;
   } rsp_type;

   // A burst of up to nine bytes queued between the front and the back.
   typedef struct packed {
      logic [CMD_BYTES-1:0][7:0] bytes;
      logic [3:0]                cnt;
      logic                      last;
      logic [1:0]                status;
   } cmd_type;

   // Queue occupancy flags seen by the two sides.
   typedef struct packed {
      logic full;
      logic empty;
   } qflags_type;

endpackage

// ----- hw/rtl/mqpaf_front.sv -----
// Front end: accepts request beats, checks lengths, tracks the open packet and queues bursts.
module mqpaf_front
   import mqpaf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   input  logic [MAX_LEN_W-1:0] max_len,
   input  qflags_type           qflags,
   output logic                 push,
   output cmd_type              push_cmd
);

   // Input stage registers.
   logic          a_valid_ff, a_valid_in;
   req_type       a_req_ff;
   logic [28:0]   a_rem_ff, a_rem_in;

   // Packet state.
   logic          open_ff, open_in;
   logic [15:0]   topic_left_ff, topic_left_in;
   logic [27:0]   payload_left_ff, payload_left_in;
   logic          id_pending_ff, id_pending_in;
   logic [15:0]   held_mid_ff, held_mid_in;

   logic          req_fire;
   logic          b_fire;
   logic [2:0]    vs;
   logic [28:0]   total;
   logic [3:0][7:0] vb;
   logic [3:0][7:0] tail;
   logic [15:0]   tl_dec;
   logic [27:0]   pl_dec;
   logic          qos_nz;

   // The input register is free when empty or when its beat moves on this cycle.
   assign req_ready = !a_valid_ff || !qflags.full;
   assign req_fire  = req_valid && req_ready;
   assign b_fire    = a_valid_ff && !qflags.full;
   assign a_valid_in = req_fire ? 1'b1 : (b_fire ? 1'b0 : a_valid_ff);
   assign a_rem_in = 29'd2 + {13'd0, req_data.topic_len} + {1'b0, req_data.body_len}
                     + ((req_data.qos != 2'd0) ? 29'd2 : 29'd0);

   // Varint size, total packet length and the varint bytes.
   always_comb begin
      if (a_rem_ff[28:21] != 8'd0) begin
         vs = 3'd4;
      end else if (a_rem_ff[20:14] != 7'd0) begin
         vs = 3'd3;
      end else if (a_rem_ff[13:7] != 7'd0) begin
         vs = 3'd2;
      end else begin
         vs = 3'd1;
      end
      total = a_rem_ff + {26'd0, vs} + 29'd1;
      for (int k = 0; k < 4; k++) begin
         vb[k] = {((a_rem_ff >> (7 * (k + 1))) != 29'd0), a_rem_ff[7 * k +: 7]};
      end
      tail[0] = a_req_ff.topic_len[15:8];
      tail[1] = a_req_ff.topic_len[7:0];
      tail[2] = a_req_ff.packet_id[15:8];
      tail[3] = a_req_ff.packet_id[7:0];
   end

   assign qos_nz = a_req_ff.qos != 2'd0;
   assign tl_dec = topic_left_ff - 16'd1;
   assign pl_dec = payload_left_ff - 28'd1;

   // Classification of the beat in the input register.
   always_comb begin
      push            = 1'b0;
      push_cmd        = '0;
      open_in         = open_ff;
      topic_left_in   = topic_left_ff;
      payload_left_in = payload_left_ff;
      id_pending_in   = id_pending_ff;
      held_mid_in     = held_mid_ff;
      unique case (a_req_ff.mode)
         MODE_PUBLISH: begin
            push            = 1'b1;
            open_in         = 1'b0;
            topic_left_in   = '0;
            payload_left_in = '0;
            id_pending_in   = 1'b0;
            if (a_rem_ff > REM_LEN_MAX) begin
               push_cmd.cnt    = 4'd1;
               push_cmd.last   = 1'b1;
               push_cmd.status = STATUS_REM_LONG;
            end else if (total > max_len) begin
               push_cmd.cnt    = 4'd1;
               push_cmd.last   = 1'b1;
               push_cmd.status = STATUS_BUF_LONG;
            end else begin
               push_cmd.bytes[0] = {PUBLISH_TYPE, a_req_ff.dup_flag, a_req_ff.qos,
                                    a_req_ff.retain_flag};
               for (int i = 1; i < CMD_BYTES; i++) begin
                  if (i <= int'(vs)) begin
                     push_cmd.bytes[i] = vb[2'(i - 1)];
                  end else if (i - 1 - int'(vs) < 4) begin
                     push_cmd.bytes[i] = tail[2'(i - 1 - int'(vs))];
                  end
               end
               // The message id follows at once when there is no topic.
               if (qos_nz && a_req_ff.topic_len == 16'd0) begin
                  push_cmd.cnt = 4'd5 + {1'b0, vs};
               end else begin
                  push_cmd.cnt = 4'd3 + {1'b0, vs};
               end
               push_cmd.status = STATUS_OK;
               held_mid_in     = a_req_ff.packet_id;
               if (a_req_ff.topic_len == 16'd0 && a_req_ff.body_len == 28'd0) begin
                  push_cmd.last = 1'b1;
               end else begin
                  open_in         = 1'b1;
                  topic_left_in   = a_req_ff.topic_len;
                  payload_left_in = a_req_ff.body_len;
                  id_pending_in   = qos_nz && (a_req_ff.topic_len != 16'd0);
               end
            end
         end
         MODE_DATA: begin
            if (open_ff) begin
               push              = 1'b1;
               push_cmd.bytes[0] = a_req_ff.data_byte;
               push_cmd.cnt      = 4'd1;
               push_cmd.status   = STATUS_OK;
               if (topic_left_ff != 16'd0) begin
                  topic_left_in = tl_dec;
               end else if (payload_left_ff != 28'd0) begin
                  payload_left_in = pl_dec;
               end
               // Insert the message id once the topic is used up.
               if (topic_left_in == 16'd0 && id_pending_ff) begin
                  push_cmd.bytes[1] = held_mid_ff[15:8];
                  push_cmd.bytes[2] = held_mid_ff[7:0];
                  push_cmd.cnt      = 4'd3;
                  id_pending_in     = 1'b0;
               end
               if (topic_left_in == 16'd0 && !id_pending_in && payload_left_in == 28'd0) begin
                  push_cmd.last   = 1'b1;
                  open_in         = 1'b0;
               end
            end
         end
         MODE_ACK: begin
            push            = 1'b1;
            open_in         = 1'b0;
            topic_left_in   = '0;
            payload_left_in = '0;
            id_pending_in   = 1'b0;
            push_cmd.last   = 1'b1;
            if (max_len < ACK_LEN) begin
               push_cmd.cnt    = 4'd1;
               push_cmd.status = STATUS_BUF_LONG;
            end else begin
               push_cmd.bytes[0] = {a_req_ff.packet_type, a_req_ff.dup_flag,
                                    1'b0, (a_req_ff.packet_type == PUBREL_TYPE), 1'b0};
               push_cmd.bytes[1] = ACK_REM_LEN;
               push_cmd.bytes[2] = a_req_ff.packet_id[15:8];
               push_cmd.bytes[3] = a_req_ff.packet_id[7:0];
               push_cmd.cnt      = 4'd4;
               push_cmd.status   = STATUS_OK;
            end
         end
         MODE_ZERO: begin
            push            = 1'b1;
            open_in         = 1'b0;
            topic_left_in   = '0;
            payload_left_in = '0;
            id_pending_in   = 1'b0;
            push_cmd.last   = 1'b1;
            if (max_len < ZERO_LEN) begin
               push_cmd.cnt    = 4'd1;
               push_cmd.status = STATUS_BUF_LONG;
            end else begin
               push_cmd.bytes[0] = {a_req_ff.packet_type, 4'd0};
               push_cmd.cnt      = 4'd2;
               push_cmd.status   = STATUS_OK;
            end
         end
         default: begin
            push = 1'b0;
         end
      endcase
      if (!b_fire) begin
         push = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff      <= 1'b0;
         open_ff         <= 1'b0;
         topic_left_ff   <= '0;
         payload_left_ff <= '0;
         id_pending_ff   <= 1'b0;
         held_mid_ff     <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         if (b_fire) begin
            open_ff         <= open_in;
            topic_left_ff   <= topic_left_in;
            payload_left_ff <= payload_left_in;
            id_pending_ff   <= id_pending_in;
            held_mid_ff     <= held_mid_in;
         end
      end
   end

   // Input stage payload.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_req_ff <= req_data;
         a_rem_ff <= a_rem_in;
      end
   end

endmodule

// ----- hw/rtl/mqpaf_queue.sv -----
// Short queue of byte bursts between the front and the back.
module mqpaf_queue
   import mqpaf_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  cmd_type    push_cmd,
   input  logic       pop,
   output cmd_type    head_cmd,
   output qflags_type qflags
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            mem [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign qflags.full  = count_ff == CNT_W'(DEPTH);
   assign qflags.empty = count_ff == '0;
   assign head_cmd     = mem[rd_ptr_ff];

   // Pointer and occupancy updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- hw/rtl/mqpaf_back.sv -----
// Back end: serialises queued bursts into single output beats.
module mqpaf_back
   import mqpaf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    head_cmd,
   input  qflags_type qflags,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff;
   logic [3:0] idx_ff, idx_in;
   logic       load;
   logic       at_end;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A new beat enters the output register when it is empty or being taken.
   assign load   = !qflags.empty && (!rsp_valid_ff || rsp_ready);
   assign at_end = idx_ff == head_cmd.cnt - 4'd1;
   assign pop    = load && at_end;

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         idx_in       = at_end ? 4'd0 : idx_ff + 4'd1;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   // Output beat payload.
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff.out_byte  <= head_cmd.bytes[idx_ff];
         rsp_ff.last_byte <= at_end && head_cmd.last;
         rsp_ff.status    <= head_cmd.status;
      end
   end

endmodule

// ----- hw/rtl/mqtt_publish_ack_framer.sv -----
// Top level of the MQTT publish, acknowledgement and zero-length packet framer.
// The block takes one request beat per cycle and gives one packet byte per cycle, unless held
// back by a full queue or a stalled receiver. A publish start beat yields four to nine bytes
// (header, one to four length bytes, topic length and, with no topic, the message id), an
// acknowledgement four, a zero-length packet two, a data beat one or three, and a rejected
// packet a single error beat. A beat passes an input register, where its lengths are checked
// and it is classified, and a queue of QUEUE_DEPTH bursts, then the output register. The output
// register emits one byte per cycle while the receiver is ready, and that serialiser sets the
// sustained rate: requests are taken every cycle while bursts average one byte, and header bursts
// hold the input back only once the queue is full and the input register holds a waiting beat.
module mqtt_publish_ack_framer
   import mqpaf_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_wr_en,
   input  logic [MAX_LEN_W-1:0] csr_wr_data
);

   logic [MAX_LEN_W-1:0] max_len_ff;
   logic                 push;
   cmd_type              push_cmd;
   logic                 pop;
   cmd_type              head_cmd;
   qflags_type           qflags;

   // Buffer capacity register.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

   mqpaf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .max_len   (max_len_ff),
      .qflags    (qflags),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   mqpaf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .qflags   (qflags)
   );

   mqpaf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_cmd  (head_cmd),
      .qflags    (qflags),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- test/mqtt_frame_monitor.sv -----
// Monitor for the MQTT framer: predicts the byte stream for every request beat and checks it.
`timescale 1ns / 1ps

module mqtt_frame_monitor
   import mqpaf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_type              rsp_data,
   input  logic                 csr_wr_en,
   input  logic [MAX_LEN_W-1:0] csr_wr_data,
   output int                   bytes_owed,
   output int                   fail_count
);

   // Predicted framer state and the buffer capacity register.
   logic                 pkt_open;
   logic [15:0]          topic_left;
   logic [27:0]          payload_left;
   logic                 id_due;
   logic [15:0]          held_id;
   logic [MAX_LEN_W-1:0] max_len;

   // Bytes predicted but not yet seen on the result channel, oldest first.
   rsp_type owed_bytes[$];
   int      errors = 0;

   function automatic rsp_type beat_of(input logic [7:0] b, input logic last,
                                       input logic [1:0] st);
      rsp_type r;
      r.out_byte  = b;
      r.last_byte = last;
      r.status    = st;
      return r;
   endfunction

   // Abandon whatever packet is in progress.
   task automatic drop_packet();
      pkt_open     = 1'b0;
      topic_left   = '0;
      payload_left = '0;
      id_due       = 1'b0;
   endtask

   // Work out the bytes that one request beat produces and queue them.
   task automatic frame_request(input req_type rq);
      rsp_type     burst [0:8];
      int          n;
      logic [31:0] rem;
      logic [31:0] vsize;
      logic [31:0] left;
      logic [7:0]  digit;
      logic        close_check;
      n = 0;
      close_check = 1'b0;
      case (rq.mode)
         MODE_PUBLISH: begin
            drop_packet();
            rem = 32'd2 + 32'(rq.topic_len) + 32'(rq.body_len)
                  + ((rq.qos != 2'd0) ? 32'd2 : 32'd0);
            if (rem > 32'(REM_LEN_MAX)) begin
               burst[n] = beat_of(8'h00, 1'b1, STATUS_REM_LONG);
               n++;
            end else begin
               vsize = (rem < 32'd128) ? 32'd1 : (rem < 32'd16384) ? 32'd2 :
                       (rem < 32'd2097152) ? 32'd3 : 32'd4;
               if (32'd1 + vsize + rem > 32'(max_len)) begin
                  burst[n] = beat_of(8'h00, 1'b1, STATUS_BUF_LONG);
                  n++;
               end else begin
                  burst[n] = beat_of({PUBLISH_TYPE, rq.dup_flag, rq.qos, rq.retain_flag},
                                     1'b0, STATUS_OK);
                  n++;
                  // Remaining length, seven bits per byte, continuation bit on top.
                  left = rem;
                  do begin
                     digit = {1'b0, left[6:0]};
                     left  = left >> 7;
                     if (left != 32'd0) begin
                        digit[7] = 1'b1;
                     end
                     burst[n] = beat_of(digit, 1'b0, STATUS_OK);
                     n++;
                  end while (left != 32'd0);
                  burst[n] = beat_of(rq.topic_len[15:8], 1'b0, STATUS_OK);
                  n++;
                  burst[n] = beat_of(rq.topic_len[7:0], 1'b0, STATUS_OK);
                  n++;
                  pkt_open     = 1'b1;
                  topic_left   = rq.topic_len;
                  payload_left = rq.body_len;
                  id_due       = (rq.qos != 2'd0);
                  held_id      = rq.packet_id;
                  close_check  = 1'b1;
               end
            end
         end
         MODE_DATA: begin
            // A data beat with no packet open is dropped silently.
            if (pkt_open) begin
               burst[n] = beat_of(rq.data_byte, 1'b0, STATUS_OK);
               n++;
               if (topic_left != 16'd0) begin
                  topic_left = topic_left - 16'd1;
               end else if (payload_left != 28'd0) begin
                  payload_left = payload_left - 28'd1;
               end
               close_check = 1'b1;
            end
         end
         MODE_ACK: begin
            drop_packet();
            if (max_len < ACK_LEN) begin
               burst[n] = beat_of(8'h00, 1'b1, STATUS_BUF_LONG);
               n++;
            end else begin
               burst[0] = beat_of({rq.packet_type, rq.dup_flag,
                                   (rq.packet_type == PUBREL_TYPE) ? 2'b01 : 2'b00, 1'b0},
                                  1'b0, STATUS_OK);
               burst[1] = beat_of(ACK_REM_LEN, 1'b0, STATUS_OK);
               burst[2] = beat_of(rq.packet_id[15:8], 1'b0, STATUS_OK);
               burst[3] = beat_of(rq.packet_id[7:0], 1'b1, STATUS_OK);
               n = 4;
            end
         end
         default: begin
            drop_packet();
            if (max_len < ZERO_LEN) begin
               burst[n] = beat_of(8'h00, 1'b1, STATUS_BUF_LONG);
               n++;
            end else begin
               burst[0] = beat_of({rq.packet_type, 4'h0}, 1'b0, STATUS_OK);
               burst[1] = beat_of(8'h00, 1'b1, STATUS_OK);
               n = 2;
            end
         end
      endcase
      // Once the topic is through, the message id follows; the packet ends when nothing is left.
      if (close_check) begin
         if (topic_left == 16'd0 && id_due) begin
            burst[n] = beat_of(held_id[15:8], 1'b0, STATUS_OK);
            n++;
            burst[n] = beat_of(held_id[7:0], 1'b0, STATUS_OK);
            n++;
            id_due = 1'b0;
         end
         if (topic_left == 16'd0 && !id_due && payload_left == 28'd0) begin
            burst[n-1].last_byte = 1'b1;
            drop_packet();
         end
      end
      for (int i = 0; i < n; i++) begin
         owed_bytes.push_back(burst[i]);
      end
   endtask

   task automatic check_field(input string field, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want) begin
         errors++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   // Everything is sampled at the rising edge, before the block's registers move.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         drop_packet();
         held_id = '0;
         max_len = MAX_LEN_RESET;
         owed_bytes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed_bytes.size() == 0) begin
               errors++;
               $display("%0t ns: unexpected result beat, expected none, actual %h/%b/%0d",
                        $time, rsp_data.out_byte, rsp_data.last_byte, rsp_data.status);
            end else begin
               want = owed_bytes.pop_front();
               check_field("out_byte", rsp_data.out_byte, want.out_byte);
               check_field("last_byte", 8'(rsp_data.last_byte), 8'(want.last_byte));
               check_field("status", 8'(rsp_data.status), 8'(want.status));
            end
         end
         if (csr_wr_en) begin
            max_len = csr_wr_data;
         end
         if (req_valid && req_ready) begin
            frame_request(req_data);
         end
      end
      bytes_owed <= owed_bytes.size();
      fail_count <= errors;
   end

endmodule

// ----- test/tb_mqtt_publish_ack_framer.sv -----
// Testbench top for the MQTT framer: clock, reset, stimulus, register writes and the verdict.
`timescale 1ns / 1ps

module tb_mqtt_publish_ack_framer;
   import mqpaf_pkg::*;

   localparam int TIMEOUT_NS    = 3_000_000;
   localparam int SETTLE_CYCLES = 12;
   localparam int GAP_PCT       = 38;

   logic                 clock;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_ready;
   req_type              req_data    = '0;
   logic                 rsp_valid;
   logic                 rsp_ready   = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_wr_en   = 1'b0;
   logic [MAX_LEN_W-1:0] csr_wr_data = '0;
   int                   bytes_owed;
   int                   fail_count;
   logic                 steady      = 1'b0;
   logic [MAX_LEN_W-1:0] buffer_limit = MAX_LEN_RESET;
   logic [MAX_LEN_W-1:0] limits [7];

   mqtt_publish_ack_framer uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   mqtt_frame_monitor frame_monitor (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .bytes_owed  (bytes_owed),
      .fail_count  (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // The receiver stalls at random except during the steady stretch.
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= GAP_PCT);
   end

   // A beat with every field random, then the mode forced.
   function automatic req_type noise_beat(input logic [1:0] mode);
      logic [95:0] bits;
      req_type     b;
      bits   = {$urandom, $urandom, $urandom};
      b      = bits[$bits(req_type)-1:0];
      b.mode = mode;
      return b;
   endfunction

   // Offer one beat and return in the time step at which it is taken.
   task automatic send_beat(input req_type b);
      if (!steady) begin
         while ($urandom_range(99) < GAP_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_publish(input logic [1:0] qos, input logic dup, input logic retain,
                               input logic [15:0] mid, input logic [15:0] tlen,
                               input logic [27:0] plen);
      req_type b;
      b             = noise_beat(MODE_PUBLISH);
      b.qos         = qos;
      b.dup_flag    = dup;
      b.retain_flag = retain;
      b.packet_id   = mid;
      b.topic_len   = tlen;
      b.body_len    = plen;
      send_beat(b);
   endtask

   task automatic send_data(input logic [7:0] value);
      req_type b;
      b           = noise_beat(MODE_DATA);
      b.data_byte = value;
      send_beat(b);
   endtask

   task automatic send_ack(input logic [3:0] ptype, input logic dup, input logic [15:0] mid);
      req_type b;
      b             = noise_beat(MODE_ACK);
      b.packet_type = ptype;
      b.dup_flag    = dup;
      b.packet_id   = mid;
      send_beat(b);
   endtask

   task automatic send_zero(input logic [3:0] ptype);
      req_type b;
      b             = noise_beat(MODE_ZERO);
      b.packet_type = ptype;
      send_beat(b);
   endtask

   // Hold the sender back until every predicted byte has arrived and the pipeline is empty.
   task automatic wait_for_quiet();
      req_valid <= 1'b0;
      do @(posedge clock); while (bytes_owed != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_max_len(input logic [MAX_LEN_W-1:0] value);
      csr_wr_data  <= value;
      csr_wr_en    <= 1'b1;
      buffer_limit  = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Mostly complete publish packets with random content; the rest is acks, zero-length
   // packets, stray data beats, truncated packets and huge lengths.
   task automatic random_traffic(input int count);
      int          done;
      int          pick;
      int          cut;
      int          rem;
      logic [15:0] tlen;
      logic [27:0] plen;
      logic [1:0]  qos;
      done = 0;
      while (done < count) begin
         pick = $urandom_range(99);
         qos  = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
         if (pick < 62) begin
            tlen = 16'($urandom_range(8));
            plen = ($urandom_range(24) == 0) ? 28'($urandom_range(100, 300))
                                            : 28'($urandom_range(24));
            send_publish(qos, 1'($urandom), 1'($urandom), 16'($urandom), tlen, plen);
            // Only stream the body if the packet will be accepted.
            rem = 2 + int'(tlen) + int'(plen) + ((qos != 2'd0) ? 2 : 0);
            cut = (rem + ((rem < 128) ? 2 : 3) <= int'(buffer_limit))
                  ? int'(tlen) + int'(plen) : 0;
            if ($urandom_range(7) == 0) begin
               cut = $urandom_range(cut);
            end
            repeat (cut) send_data(8'($urandom));
            done += 1 + cut;
         end else if (pick < 74) begin
            send_ack(($urandom_range(3) == 0) ? PUBREL_TYPE : 4'($urandom), 1'($urandom),
                     16'($urandom));
            done++;
         end else if (pick < 84) begin
            send_zero(4'($urandom));
            done++;
         end else if (pick < 92) begin
            // Usually lands while idle and is dropped, so it does not count.
            send_data(8'($urandom));
         end else begin
            send_publish(qos, 1'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
                         28'($urandom));
            done++;
         end
      end
   endtask

   initial begin
      #(TIMEOUT_NS);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      limits[0] = 29'd268435460;
      limits[1] = 29'd2;
      limits[2] = 29'd3;
      limits[3] = 29'd4;
      limits[4] = 29'd40;
      limits[5] = 29'd300;
      limits[6] = 29'($urandom_range(5, 100000));
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Traffic at the reset capacity before the register is ever written.
      random_traffic(28);

      for (int p = 0; p < 7; p++) begin
         wait_for_quiet();
         write_max_len(limits[p]);
         if (p == 0) begin
            // Empty packets ending at the topic length and at the message id.
            send_publish(2'd0, 1'b0, 1'b0, 16'h0000, 16'd0, 28'd0);
            send_publish(2'd1, 1'b0, 1'b0, 16'hA55A, 16'd0, 28'd0);
            // Topic, inserted message id, then payload.
            send_publish(2'd2, 1'b1, 1'b1, 16'hFFFF, 16'd2, 28'd3);
            send_data(8'h00);
            send_data(8'hFF);
            send_data(8'h80);
            send_data(8'h7F);
            send_data(8'h5A);
            // Qos three goes into the header as given and carries an id.
            send_publish(2'd3, 1'b0, 1'b1, 16'h1234, 16'd1, 28'd1);
            send_data(8'h33);
            send_data(8'hCC);
            // Data with nothing open is dropped.
            send_data(8'hC3);
            // Remaining length on each side of the varint size boundaries; each start
            // abandons the packet before it.
            send_publish(2'd0, 1'b0, 1'b0, 16'd0, 16'd0, 28'd125);
            send_publish(2'd0, 1'b0, 1'b0, 16'd0, 16'd0, 28'd126);
            send_publish(2'd1, 1'b0, 1'b0, 16'd7, 16'd0, 28'd16379);
            send_publish(2'd0, 1'b0, 1'b0, 16'd0, 16'd0, 28'd16382);
            send_publish(2'd0, 1'b0, 1'b0, 16'd0, 16'd65535, 28'd2031614);
            send_publish(2'd0, 1'b0, 1'b0, 16'd0, 16'd65535, 28'd2031615);
            // Largest legal remaining length, exactly filling the largest buffer.
            send_publish(2'd0, 1'b1, 1'b1, 16'd9, 16'd65535, 28'd268369918);
            send_data(8'hAA);
            // Acks and zero-length packets, the first abandoning the open packet.
            send_ack(PUBREL_TYPE, 1'b1, 16'hBEEF);
            send_ack(4'd4, 1'b0, 16'h0000);
            send_ack(4'd15, 1'b1, 16'hFFFF);
            send_zero(4'd12);
            send_zero(4'd14);
            send_zero(4'd0);
            // Remaining length over the protocol maximum, far and just over.
            send_publish(2'd3, 1'b1, 1'b1, 16'hFFFF, 16'd65535, 28'd268435455);
            send_publish(2'd0, 1'b0, 1'b0, 16'd0, 16'd1, 28'd268435453);
            // A packet cut short by a zero-length packet.
            send_publish(2'd2, 1'b0, 1'b0, 16'h0102, 16'd2, 28'd2);
            send_data(8'h41);
            send_zero(4'd13);
         end
         if (p == 4) begin
            steady <= 1'b1;
         end
         random_traffic(28);
         if (p % 2 == 1) begin
            wait_for_quiet();
         end
         random_traffic(28);
         steady <= 1'b0;
      end

      wait_for_quiet();
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/mqpaf_pkg.sv
hw/rtl/mqpaf_front.sv
hw/rtl/mqpaf_queue.sv
hw/rtl/mqpaf_back.sv
hw/rtl/mqtt_publish_ack_framer.sv
test/mqtt_frame_monitor.sv
test/tb_mqtt_publish_ack_framer.sv
